// File: rtl/sparse_polynomial_multiply_unit_defines.svh
// Assertion macros shared by the sparse polynomial multiply unit.
// Depends on nothing; included by the modules that check their own logic.
`ifndef SPARSE_POLYNOMIAL_MULTIPLY_UNIT_DEFINES_SVH
`define SPARSE_POLYNOMIAL_MULTIPLY_UNIT_DEFINES_SVH
// Checks that a condition implies another in the same cycle.
`define SPM_ASSERT_IMP(lbl, clk_s, rst_n, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication failed");
// Checks that a condition implies another in the next cycle.
`define SPM_ASSERT_NEXT(lbl, clk_s, rst_n, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle implication failed");
`endif

// File: rtl/spm_pkg.sv
// Package of the sparse polynomial multiply unit: widths, constants and types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;
	localparam int MaxTerms = 8;
	localparam int ProdCap = MaxTerms * MaxTerms;
	localparam int TermIdxW = $clog2(MaxTerms);
	localparam int TermCntW = $clog2(MaxTerms + 1);
	localparam int ProdIdxW = $clog2(ProdCap);
	localparam int ProdCntW = $clog2(ProdCap + 1);
	localparam int CoefW = 16;
	localparam int ExpoW = 8;
	localparam int PcoefW = 38;
	localparam int PexpoW = 9;
	localparam int QDepth = 2;

	typedef struct packed {
		logic signed [CoefW-1:0] coef;
		logic [ExpoW-1:0] expo;
	} term_t;

	typedef struct packed {
		logic signed [PcoefW-1:0] coef;
		logic [PexpoW-1:0] expo;
	} prod_t;

	// One queue entry per accepted term: it may load the term, close the job, or both.
	typedef struct packed {
		logic kind;
		logic close;
		logic load;
		logic [TermIdxW-1:0] slot;
		term_t term;
		logic ovf;
	} cmd_t;
endpackage
`default_nettype wire

// File: rtl/spm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module spm_ram #(
	parameter int Width = 8,
	parameter int Depth = 8
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/spm_front.sv
// Front part: accepts terms, counts them per polynomial and flags overflow.
// Depends on spm_pkg; feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_polynomial_multiply_unit_defines.svh"
module spm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic kind,
	input wire logic signed [spm_pkg::CoefW-1:0] coefficient,
	input wire logic [spm_pkg::ExpoW-1:0] exponent,
	input wire logic last_term,
	output logic cmd_valid,
	input wire logic cmd_full,
	output spm_pkg::cmd_t cmd,
	input wire logic job_done
);
	logic [spm_pkg::TermCntW-1:0] first_cnt_q, second_cnt_q;
	logic ovf_q, busy_q, acc, has_room, closing;

	// Once a job closes, input waits until the back part has emitted it.
	assign in_stall = busy_q || cmd_full;
	assign acc = in_valid && !in_stall;
	assign has_room = kind ? (second_cnt_q < spm_pkg::TermCntW'(spm_pkg::MaxTerms))
		: (first_cnt_q < spm_pkg::TermCntW'(spm_pkg::MaxTerms));
	assign closing = kind && last_term;
	assign cmd_valid = acc;

	always_comb begin
		cmd.kind = kind;
		cmd.close = closing;
		cmd.load = has_room;
		cmd.slot = kind ? second_cnt_q[spm_pkg::TermIdxW-1:0]
			: first_cnt_q[spm_pkg::TermIdxW-1:0];
		cmd.term.coef = coefficient;
		cmd.term.expo = exponent;
		cmd.ovf = ovf_q || !has_room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q <= '0;
			second_cnt_q <= '0;
			ovf_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (job_done) begin
				busy_q <= 1'b0;
			end
			if (acc) begin
				if (closing) begin
					first_cnt_q <= '0;
					second_cnt_q <= '0;
					ovf_q <= 1'b0;
					busy_q <= 1'b1;
				end else begin
					if (!has_room) begin
						ovf_q <= 1'b1;
					end else if (kind) begin
						second_cnt_q <= second_cnt_q + 1'b1;
					end else begin
						first_cnt_q <= first_cnt_q + 1'b1;
					end
				end
			end
		end
	end

	`SPM_ASSERT_IMP(a_cnt_first, clk, arst_n, 1'b1,
		first_cnt_q <= spm_pkg::TermCntW'(spm_pkg::MaxTerms))
	`SPM_ASSERT_IMP(a_cnt_second, clk, arst_n, 1'b1,
		second_cnt_q <= spm_pkg::TermCntW'(spm_pkg::MaxTerms))
	`SPM_ASSERT_NEXT(a_close_busy, clk, arst_n, acc && closing, busy_q)
endmodule
`default_nettype wire

// File: rtl/spm_queue.sv
// Short command queue between the front and back parts.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spm_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire spm_pkg::cmd_t push_data,
	output logic full,
	output logic not_empty,
	input wire logic pop,
	output spm_pkg::cmd_t pop_data
);
	spm_pkg::cmd_t ent_q [spm_pkg::QDepth];
	logic [$clog2(spm_pkg::QDepth)-1:0] wp_q, rp_q;
	logic [$clog2(spm_pkg::QDepth+1)-1:0] cnt_q;

	assign full = cnt_q == ($clog2(spm_pkg::QDepth+1))'(spm_pkg::QDepth);
	assign not_empty = cnt_q != '0;
	assign pop_data = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{($clog2(spm_pkg::QDepth+1)-1){1'b0}}, push}
				- {{($clog2(spm_pkg::QDepth+1)-1){1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/spm_back.sv
// Back part: stores terms, multiplies every pair, merges products into a
// sorted table held in RAM, then emits it. Depends on spm_pkg and spm_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_polynomial_multiply_unit_defines.svh"
module spm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_ready,
	input wire spm_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic job_done,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [spm_pkg::PcoefW-1:0] product_coefficient,
	output logic [spm_pkg::PexpoW-1:0] product_exponent,
	output logic final_term,
	output logic dropped
);
	typedef enum logic [3:0] {
		S_IDLE, S_RDT, S_MUL, S_SRCH, S_SRCHW, S_SHRD, S_SHRDW, S_SHWR,
		S_INS, S_NEXT, S_ERD, S_ERDW, S_EOUT
	} state_t;

	state_t state_q;
	spm_pkg::term_t first_q [spm_pkg::MaxTerms];
	spm_pkg::term_t second_q [spm_pkg::MaxTerms];
	logic [spm_pkg::TermCntW-1:0] fcnt_q, scnt_q;
	logic [spm_pkg::TermIdxW-1:0] i_q, j_q;
	logic ovf_q;
	logic signed [31:0] mul_q;
	logic [spm_pkg::PexpoW-1:0] pexp_q;
	logic [spm_pkg::ProdCntW-1:0] pcnt_q, pos_q, k_q;
	logic we;
	logic [spm_pkg::ProdIdxW-1:0] waddr, raddr;
	spm_pkg::prod_t wdata, rdata;
	spm_pkg::term_t fa_q, sb_q;

	spm_ram #(.Width($bits(spm_pkg::prod_t)), .Depth(spm_pkg::ProdCap)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign cmd_pop = (state_q == S_IDLE) && cmd_ready;
	assign out_valid = state_q == S_EOUT;

	always_comb begin
		raddr = pos_q[spm_pkg::ProdIdxW-1:0];
		if (state_q == S_SHRD || state_q == S_SHRDW) begin
			raddr = spm_pkg::ProdIdxW'(k_q - 1'b1);
		end
		we = 1'b0;
		waddr = pos_q[spm_pkg::ProdIdxW-1:0];
		wdata.coef = spm_pkg::PcoefW'(mul_q);
		wdata.expo = pexp_q;
		if (state_q == S_SRCHW && pos_q < pcnt_q && rdata.expo == pexp_q) begin
			we = 1'b1;
			wdata.coef = rdata.coef + spm_pkg::PcoefW'(mul_q);
		end else if (state_q == S_SHWR) begin
			we = 1'b1;
			waddr = k_q[spm_pkg::ProdIdxW-1:0];
			wdata = rdata;
		end else if (state_q == S_INS) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fcnt_q <= '0;
			scnt_q <= '0;
			ovf_q <= 1'b0;
			job_done <= 1'b0;
			pcnt_q <= '0;
			pos_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			mul_q <= '0;
			pexp_q <= '0;
			product_coefficient <= '0;
			product_exponent <= '0;
			final_term <= 1'b0;
			dropped <= 1'b0;
			fa_q <= '0;
			sb_q <= '0;
		end else begin
			job_done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_ready) begin
						if (cmd.load) begin
							if (cmd.kind) begin
								second_q[cmd.slot] <= cmd.term;
								scnt_q <= scnt_q + 1'b1;
							end else begin
								first_q[cmd.slot] <= cmd.term;
								fcnt_q <= fcnt_q + 1'b1;
							end
						end
						ovf_q <= cmd.ovf;
						if (cmd.close) begin
							i_q <= '0;
							j_q <= '0;
							pcnt_q <= '0;
							if (fcnt_q == '0 || (scnt_q == '0 && !cmd.load)) begin
								product_coefficient <= '0;
								product_exponent <= '0;
								final_term <= 1'b1;
								dropped <= cmd.ovf;
								state_q <= S_EOUT;
							end else begin
								state_q <= S_RDT;
							end
						end
					end
				end
				S_RDT: begin
					fa_q <= first_q[i_q];
					sb_q <= second_q[j_q];
					state_q <= S_MUL;
				end
				S_MUL: begin
					mul_q <= 32'(fa_q.coef * sb_q.coef);
					pexp_q <= spm_pkg::PexpoW'(fa_q.expo) + spm_pkg::PexpoW'(sb_q.expo);
					pos_q <= '0;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					state_q <= S_SRCHW;
				end
				S_SRCHW: begin
					if (pos_q < pcnt_q && rdata.expo < pexp_q) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_SRCH;
					end else if (pos_q < pcnt_q && rdata.expo == pexp_q) begin
						state_q <= S_NEXT;
					end else begin
						k_q <= pcnt_q;
						state_q <= (pcnt_q > pos_q) ? S_SHRD : S_INS;
					end
				end
				S_SHRD: begin
					state_q <= S_SHRDW;
				end
				S_SHRDW: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					k_q <= k_q - 1'b1;
					state_q <= (k_q - 1'b1 > pos_q) ? S_SHRD : S_INS;
				end
				S_INS: begin
					pcnt_q <= pcnt_q + 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (spm_pkg::TermCntW'(j_q) + 1'b1 < scnt_q) begin
						j_q <= j_q + 1'b1;
						state_q <= S_RDT;
					end else if (spm_pkg::TermCntW'(i_q) + 1'b1 < fcnt_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= S_RDT;
					end else begin
						pos_q <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					state_q <= S_ERDW;
				end
				S_ERDW: begin
					product_coefficient <= rdata.coef;
					product_exponent <= rdata.expo;
					final_term <= pos_q + 1'b1 == pcnt_q;
					dropped <= ovf_q;
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (!out_stall) begin
						if (final_term) begin
							fcnt_q <= '0;
							scnt_q <= '0;
							ovf_q <= 1'b0;
							job_done <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SPM_ASSERT_IMP(a_pcnt_cap, clk, arst_n, 1'b1,
		pcnt_q <= spm_pkg::ProdCntW'(spm_pkg::ProdCap))
	`SPM_ASSERT_NEXT(a_done_idle, clk, arst_n, job_done, state_q == S_IDLE)
	`SPM_ASSERT_IMP(a_pop_idle, clk, arst_n, cmd_pop, !out_valid)
endmodule
`default_nettype wire

// File: rtl/sparse_polynomial_multiply_unit.sv
// Top level of the sparse polynomial multiply unit.
// Depends on spm_pkg, spm_front, spm_queue and spm_back.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  kind, coefficient, exponent, last_term
// out      output     out_valid/out_stall product_coefficient, product_exponent,
//                                          final_term, dropped
//
// A term that does not close the job is accepted while the command queue has room.
// The closing term starts a multiply-merge walk that multiplies every pair of terms and
// merges each product into the sorted table of P products, then emits each product.
// Input is stalled from the closing term until the last product is taken and job_done
// has cleared the front part's busy flag.
// Reset is asynchronous and clears all counts and control state.
`timescale 1ns / 1ps
`default_nettype none
module sparse_polynomial_multiply_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic kind,
	input wire logic signed [spm_pkg::CoefW-1:0] coefficient,
	input wire logic [spm_pkg::ExpoW-1:0] exponent,
	input wire logic last_term,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [spm_pkg::PcoefW-1:0] product_coefficient,
	output logic [spm_pkg::PexpoW-1:0] product_exponent,
	output logic final_term,
	output logic dropped
);
	spm_pkg::cmd_t push_cmd, pop_cmd;
	logic push, full, not_empty, pop, job_done;

	spm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .coefficient(coefficient), .exponent(exponent),
		.last_term(last_term), .cmd_valid(push), .cmd_full(full), .cmd(push_cmd),
		.job_done(job_done)
	);

	spm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_cmd), .full(full),
		.not_empty(not_empty), .pop(pop), .pop_data(pop_cmd)
	);

	spm_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_ready(not_empty), .cmd(pop_cmd),
		.cmd_pop(pop), .job_done(job_done), .out_valid(out_valid),
		.out_stall(out_stall), .product_coefficient(product_coefficient),
		.product_exponent(product_exponent), .final_term(final_term),
		.dropped(dropped)
	);
endmodule
`default_nettype wire
